/* hw/rtl/sprs_pkg.sv */
`default_nettype none

package sprs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int INDEX_BITS  = 20;
  localparam int DATA_W      = 64;

  // Width of a slot index into the stores and of a record count.
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  localparam int REC_W   = 2 * INDEX_BITS + 3 * DATA_W;
  localparam int TDATA_W = ((REC_W + 7) / 8) * 8;

  // Entries in the queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Packed so that the row index sits in the lowest bits.
  typedef struct packed {
    logic [DATA_W-1:0]     shift_y_bits;
    logic [DATA_W-1:0]     shift_x_bits;
    logic [DATA_W-1:0]     term_bits;
    logic [INDEX_BITS-1:0] col_index;
    logic [INDEX_BITS-1:0] row_index;
  } rec_t;

  // One classified transaction handed from the front to the back.
  typedef struct packed {
    rec_t rec;
    logic keep;   // record fits and is to be stored
    logic last;   // closes the batch
    logic ovf;    // batch has dropped a record so far
  } q_item_t;

endpackage

`default_nettype wire

/* hw/rtl/sprs_ram.sv */
`default_nettype none

module sprs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sprs_front.sv */
`default_nettype none

module sprs_front
  import sprs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,
  input  wire logic               in_tlast,
  output logic                    push,
  output q_item_t                 push_item,
  input  wire logic               q_full
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             drop_r, drop_nxt;
  logic             keep;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;
  assign keep      = (count_r < CNT_W'(MAX_RECORDS));

  assign push_item.rec  = rec_t'(in_tdata[REC_W-1:0]);
  assign push_item.keep = keep;
  assign push_item.last = in_tlast;
  assign push_item.ovf  = drop_r || !keep;

  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (push) begin
      if (in_tlast) begin
        count_nxt = '0;
        drop_nxt  = 1'b0;
      end else begin
        count_nxt = keep ? count_r + CNT_W'(1) : count_r;
        drop_nxt  = drop_r || !keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sprs_queue.sv */
`default_nettype none

module sprs_queue
  import sprs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  q_item_t   push_item,
  output logic      full,
  output logic      pop_valid,
  output q_item_t   pop_item,
  input  wire logic pop_ready
);

  q_item_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] used_r, used_nxt;
  logic              pop;

  assign full      = (used_r == QCNT_W'(QDEPTH));
  assign pop_valid = (used_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    used_nxt = used_r;
    if (push && !pop) begin
      used_nxt = used_r + QCNT_W'(1);
    end else if (pop && !push) begin
      used_nxt = used_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      used_r   <= '0;
    end else begin
      used_r <= used_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sprs_back.sv */
`default_nettype none

module sprs_back
  import sprs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  q_item_t                 q_item,
  output logic                    q_ready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [TDATA_W-1:0] out_tdata,
  output logic                    out_tlast,
  output logic                    out_tuser
);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_SORT = 4'b0010,
    S_RD   = 4'b0100,
    S_EMIT = 4'b1000
  } bk_state_t;

  bk_state_t state_r, state_nxt;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      pass_r, pass_nxt;
  logic [CNT_W-1:0]      emit_k_r, emit_k_nxt;
  logic                  ovf_r, ovf_nxt;

  // Sort row: key and arrival slot of each stored record.
  logic [INDEX_BITS-1:0] key_r [MAX_RECORDS];
  logic [INDEX_BITS-1:0] key_nxt [MAX_RECORDS];
  logic [IDX_W-1:0]      idx_r [MAX_RECORDS];
  logic [IDX_W-1:0]      idx_nxt [MAX_RECORDS];
  logic [MAX_RECORDS-2:0] swap;

  rec_t                  out_rec_r, out_rec_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  ram_we, ram_re;
  logic [REC_W-1:0]      ram_rdata;
  logic [IDX_W-1:0]      load_slot;

  assign load_slot = cnt_r[IDX_W-1:0];
  assign q_ready   = (state_r == S_LOAD);

  sprs_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_RECORDS)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(load_slot),
    .wr_data(q_item.rec),
    .rd_en  (ram_re),
    .rd_addr(idx_r[0]),
    .rd_data(ram_rdata)
  );

  // Odd-even transposition: in each pass, pairs starting at the pass parity
  // swap on a strictly greater left key, which keeps equal keys in order.
  always_comb begin
    for (int i = 0; i < MAX_RECORDS - 1; i++) begin
      swap[i] = (1'(i) == pass_r[0]) && (CNT_W'(i + 1) < cnt_r) &&
                (key_r[i] > key_r[i + 1]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    emit_k_nxt    = emit_k_r;
    ovf_nxt       = ovf_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    out_rec_nxt   = out_rec_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        if (q_valid) begin
          if (q_item.keep) begin
            key_nxt[load_slot] = q_item.rec.col_index;
            idx_nxt[load_slot] = load_slot;
            ram_we             = 1'b1;
            cnt_nxt            = cnt_r + CNT_W'(1);
          end
          if (q_item.last) begin
            ovf_nxt   = q_item.ovf;
            pass_nxt  = '0;
            state_nxt = S_SORT;
          end
        end
      end
      S_SORT: begin
        for (int i = 0; i < MAX_RECORDS - 1; i++) begin
          if (swap[i]) begin
            key_nxt[i]     = key_r[i + 1];
            key_nxt[i + 1] = key_r[i];
            idx_nxt[i]     = idx_r[i + 1];
            idx_nxt[i + 1] = idx_r[i];
          end
        end
        pass_nxt = pass_r + CNT_W'(1);
        if (pass_r == cnt_r - CNT_W'(1)) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_re = 1'b1;
        for (int j = 0; j < MAX_RECORDS - 1; j++) begin
          idx_nxt[j] = idx_r[j + 1];
        end
        idx_nxt[MAX_RECORDS-1] = '0;
        emit_k_nxt = '0;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_rec_nxt   = rec_t'(ram_rdata);
          out_last_nxt  = (emit_k_r + CNT_W'(1) == cnt_r);
          out_ovf_nxt   = ovf_r;
          if (emit_k_r + CNT_W'(1) == cnt_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            ram_re = 1'b1;
            for (int j = 0; j < MAX_RECORDS - 1; j++) begin
              idx_nxt[j] = idx_r[j + 1];
            end
            idx_nxt[MAX_RECORDS-1] = '0;
            emit_k_nxt = emit_k_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    pass_r    <= pass_nxt;
    emit_k_r  <= emit_k_nxt;
    ovf_r     <= ovf_nxt;
    out_rec_r <= out_rec_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_rec_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

`default_nettype wire

/* hw/rtl/stable_pair_record_sorter.sv */
// Flow: the back end loads one record per cycle while the queue offers them,
// sorts the batch in n passes once the end-marked record arrives, reads the
// first payload, then emits one record per cycle while the sink keeps up.
// Reset: rst_n is synchronous and active low; it empties the queue and the
// batch counts. Record stores are not cleared and need no clearing pass.
`default_nettype none

module stable_pair_record_sorter
  import sprs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input records.
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // From bit 0: row_index, col_index, term_bits, shift_x_bits, shift_y_bits.
  input  wire logic [TDATA_W-1:0] in_tdata,
  // batch_end: marks the final record of a batch.
  input  wire logic               in_tlast,
  // Sorted results.
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // From bit 0: out_row_index, out_col_index, out_term_bits,
  // out_shift_x_bits, out_shift_y_bits.
  output logic      [TDATA_W-1:0] out_tdata,
  // final_record: last result of the batch.
  output logic                    out_tlast,
  // overflow: the batch lost records beyond capacity.
  output logic                    out_tuser
);

  // The front classifies each incoming transaction: it keeps its own count
  // of the batch, marks records that no longer fit as dropped, and carries
  // the running overflow flag along. The two-entry queue lets the front
  // keep accepting the next batch while the back end is still sorting.
  logic    push;
  q_item_t push_item;
  logic    q_full;
  logic    q_valid;
  q_item_t q_item;
  logic    q_ready;

  sprs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .push     (push),
    .push_item(push_item),
    .q_full   (q_full)
  );

  sprs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop_valid(q_valid),
    .pop_item (q_item),
    .pop_ready(q_ready)
  );

  // The back end stores kept records into the payload memory and a row of
  // key cells, runs an odd-even transposition sort over the keys for n
  // passes when the batch closes, then reads the payloads in sorted order
  // into the output register, one per cycle while the sink keeps up.
  sprs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // A full queue always has something to offer the back end.
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> q_valid)
    else $error("queue reports full while empty");

  // After a push, the queue offers a transaction to the back end in the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> q_valid)
    else $error("pushed transaction not visible in queue");

  // A result that the sink stalls stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled result changed or was withdrawn");

endmodule

`default_nettype wire
